// ===== rtl/core/tpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the packet traffic counters.
package tpc_pkg;

	localparam int NUM_LOCAL = 4;
	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 64;
	localparam int LEN_W     = 16;
	localparam int PROTO_W   = 8;
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;
	localparam int CFG_CNT_W = 3;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
	localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;
	localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;

	localparam logic [31:0] FLOOR_RESET   = 32'd102;
	localparam logic [31:0] CEILING_RESET = 32'd51200;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ADDR_COUNT = 3'd0,
		REG_LOCAL_0    = 3'd1,
		REG_LOCAL_1    = 3'd2,
		REG_LOCAL_2    = 3'd3,
		REG_LOCAL_3    = 3'd4,
		REG_FLOOR      = 3'd5,
		REG_CEILING    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_CNT_W-1:0]               addr_count;
		logic [NUM_LOCAL-1:0][ADDR_W-1:0]   local_addr;
		logic [31:0]                        alert_floor;
		logic [31:0]                        alert_ceiling;
	} cfg_t;

	typedef struct packed {
		logic is_in;
		logic is_out;
		logic is_tcp;
		logic is_udp;
		logic is_icmp;
	} cls_t;

	typedef struct packed {
		logic             upd;
		logic             op;
		logic [LEN_W-1:0] len;
		cls_t             cls;
	} upd_t;

	typedef struct packed {
		logic [CNT_W-1:0] octets_all;
		logic [CNT_W-1:0] octets_in;
		logic [CNT_W-1:0] octets_out;
		logic [CNT_W-1:0] octets_tcp;
		logic [CNT_W-1:0] octets_udp;
		logic [CNT_W-1:0] octets_icmp;
		logic [CNT_W-1:0] packet_total;
		logic [CNT_W-1:0] rate_bytes;
		logic             rate_valid;
		logic             low_rate_alert;
	} res_t;

endpackage

// ===== rtl/core/tpc_regs.sv =====
`timescale 1ns / 1ps
// APB configuration registers: local addresses and alert window.
module tpc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpc_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output tpc_pkg::cfg_t                 cfg
);

	tpc_pkg::cfg_t      cfg_q;
	tpc_pkg::reg_idx_t  idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = tpc_pkg::reg_idx_t'(paddr[tpc_pkg::PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.addr_count    <= '0;
			cfg_q.local_addr    <= '0;
			cfg_q.alert_floor   <= tpc_pkg::FLOOR_RESET;
			cfg_q.alert_ceiling <= tpc_pkg::CEILING_RESET;
		end else if (wr_en) begin
			case (idx)
				tpc_pkg::REG_ADDR_COUNT: begin
					cfg_q.addr_count <= pwdata[tpc_pkg::CFG_CNT_W-1:0];
				end
				tpc_pkg::REG_LOCAL_0: begin
					cfg_q.local_addr[0] <= pwdata;
				end
				tpc_pkg::REG_LOCAL_1: begin
					cfg_q.local_addr[1] <= pwdata;
				end
				tpc_pkg::REG_LOCAL_2: begin
					cfg_q.local_addr[2] <= pwdata;
				end
				tpc_pkg::REG_LOCAL_3: begin
					cfg_q.local_addr[3] <= pwdata;
				end
				tpc_pkg::REG_FLOOR: begin
					cfg_q.alert_floor <= pwdata;
				end
				tpc_pkg::REG_CEILING: begin
					cfg_q.alert_ceiling <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			tpc_pkg::REG_ADDR_COUNT: prdata = 32'(cfg_q.addr_count);
			tpc_pkg::REG_LOCAL_0:    prdata = cfg_q.local_addr[0];
			tpc_pkg::REG_LOCAL_1:    prdata = cfg_q.local_addr[1];
			tpc_pkg::REG_LOCAL_2:    prdata = cfg_q.local_addr[2];
			tpc_pkg::REG_LOCAL_3:    prdata = cfg_q.local_addr[3];
			tpc_pkg::REG_FLOOR:      prdata = cfg_q.alert_floor;
			tpc_pkg::REG_CEILING:    prdata = cfg_q.alert_ceiling;
			default:                 prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/tpc_classify.sv =====
`timescale 1ns / 1ps
// Direction and protocol classification of one packet header.
module tpc_classify (
	input  tpc_pkg::cfg_t                  cfg,
	input  logic [tpc_pkg::ADDR_W-1:0]     src_addr,
	input  logic [tpc_pkg::ADDR_W-1:0]     dst_addr,
	input  logic [tpc_pkg::PROTO_W-1:0]    ip_protocol,
	output tpc_pkg::cls_t                  cls
);

	logic [tpc_pkg::NUM_LOCAL-1:0] used;
	logic [tpc_pkg::NUM_LOCAL-1:0] src_hit;
	logic [tpc_pkg::NUM_LOCAL-1:0] dst_hit;
	logic                          src_local;
	logic                          dst_local;

	// a count above the register count saturates naturally here
	always_comb begin
		for (int i = 0; i < tpc_pkg::NUM_LOCAL; i++) begin
			used[i]    = cfg.addr_count > tpc_pkg::CFG_CNT_W'(i);
			src_hit[i] = used[i] && (cfg.local_addr[i] == src_addr);
			dst_hit[i] = used[i] && (cfg.local_addr[i] == dst_addr);
		end
	end

	assign src_local   = |src_hit;
	assign dst_local   = |dst_hit;
	assign cls.is_out  = !dst_local && src_local;
	assign cls.is_in   = !cls.is_out;
	assign cls.is_tcp  = ip_protocol == tpc_pkg::PROTO_TCP;
	assign cls.is_udp  = ip_protocol == tpc_pkg::PROTO_UDP;
	assign cls.is_icmp = ip_protocol == tpc_pkg::PROTO_ICMP;

endmodule

// ===== rtl/core/tpc_counters.sv =====
`timescale 1ns / 1ps
// Byte and packet counters, tick latch and rate window check.
module tpc_counters (
	input  logic           clk,
	input  logic           arst_n,
	input  tpc_pkg::upd_t  upd,
	input  tpc_pkg::cfg_t  cfg,
	output tpc_pkg::res_t  nxt
);

	logic [tpc_pkg::CNT_W-1:0] byte_total_q;
	logic [tpc_pkg::CNT_W-1:0] byte_in_q;
	logic [tpc_pkg::CNT_W-1:0] byte_out_q;
	logic [tpc_pkg::CNT_W-1:0] byte_tcp_q;
	logic [tpc_pkg::CNT_W-1:0] byte_udp_q;
	logic [tpc_pkg::CNT_W-1:0] byte_icmp_q;
	logic [tpc_pkg::CNT_W-1:0] pkt_count_q;
	logic [tpc_pkg::CNT_W-1:0] prior_total_q;
	logic [tpc_pkg::CNT_W-1:0] rate_hold_q;
	logic                      primed_q;
	logic                      rate_seen_q;

	logic [tpc_pkg::CNT_W-1:0] len64;
	logic [tpc_pkg::CNT_W-1:0] diff;
	logic                      is_pkt;
	logic                      is_tick;
	logic                      take_rate;

	assign len64     = tpc_pkg::CNT_W'(upd.len);
	assign is_pkt    = upd.op == tpc_pkg::OP_PACKET;
	assign is_tick   = upd.op == tpc_pkg::OP_TICK;
	assign take_rate = is_tick && primed_q;
	assign diff      = byte_total_q - prior_total_q;

	always_comb begin
		nxt.octets_all     = byte_total_q;
		nxt.octets_in      = byte_in_q;
		nxt.octets_out     = byte_out_q;
		nxt.octets_tcp     = byte_tcp_q;
		nxt.octets_udp     = byte_udp_q;
		nxt.octets_icmp    = byte_icmp_q;
		nxt.packet_total   = pkt_count_q;
		nxt.rate_bytes     = rate_hold_q;
		nxt.rate_valid     = rate_seen_q;
		nxt.low_rate_alert = 1'b0;
		if (is_pkt) begin
			nxt.octets_all   = byte_total_q + len64;
			nxt.packet_total = pkt_count_q + tpc_pkg::CNT_W'(1);
			if (upd.cls.is_in) begin
				nxt.octets_in = byte_in_q + len64;
			end
			if (upd.cls.is_out) begin
				nxt.octets_out = byte_out_q + len64;
			end
			if (upd.cls.is_tcp) begin
				nxt.octets_tcp = byte_tcp_q + len64;
			end
			if (upd.cls.is_udp) begin
				nxt.octets_udp = byte_udp_q + len64;
			end
			if (upd.cls.is_icmp) begin
				nxt.octets_icmp = byte_icmp_q + len64;
			end
		end else if (take_rate) begin
			nxt.rate_bytes     = diff;
			nxt.rate_valid     = 1'b1;
			nxt.low_rate_alert = (diff > tpc_pkg::CNT_W'(cfg.alert_floor)) &&
				(diff < tpc_pkg::CNT_W'(cfg.alert_ceiling));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_total_q  <= '0;
			byte_in_q     <= '0;
			byte_out_q    <= '0;
			byte_tcp_q    <= '0;
			byte_udp_q    <= '0;
			byte_icmp_q   <= '0;
			pkt_count_q   <= '0;
			prior_total_q <= '0;
			rate_hold_q   <= '0;
			primed_q      <= 1'b0;
			rate_seen_q   <= 1'b0;
		end else if (upd.upd) begin
			byte_total_q <= nxt.octets_all;
			byte_in_q    <= nxt.octets_in;
			byte_out_q   <= nxt.octets_out;
			byte_tcp_q   <= nxt.octets_tcp;
			byte_udp_q   <= nxt.octets_udp;
			byte_icmp_q  <= nxt.octets_icmp;
			pkt_count_q  <= nxt.packet_total;
			rate_hold_q  <= nxt.rate_bytes;
			rate_seen_q  <= nxt.rate_valid;
			if (is_tick) begin
				primed_q      <= 1'b1;
				prior_total_q <= byte_total_q;
			end
		end
	end

`ifndef SYNTHESIS
	a_dir_sum: assert property (@(posedge clk) disable iff (!arst_n)
		byte_in_q + byte_out_q == byte_total_q)
		else $error("direction counters do not sum to total");

	a_pkt_step: assert property (@(posedge clk) disable iff (!arst_n)
		upd.upd && is_pkt |=> pkt_count_q == $past(pkt_count_q) + tpc_pkg::CNT_W'(1))
		else $error("packet count did not advance by one");

	a_tick_hold: assert property (@(posedge clk) disable iff (!arst_n)
		upd.upd && is_tick |=> byte_total_q == $past(byte_total_q) &&
			prior_total_q == byte_total_q && primed_q)
		else $error("tick changed the byte total or missed the latch");
`endif

endmodule

// ===== rtl/core/packet_traffic_counters_core.sv =====
`timescale 1ns / 1ps
// Top level of the packet traffic counters: input stage, update, result stage.
//
//  channel | handshake              | word
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_ready    | op, packet_length, src/dst_addr, ip_protocol
//  out     | out_valid / out_ready  | seven counters, rate_bytes, flags
//  cfg     | APB psel/penable/pready| seven 32-bit registers at 4*index
//
// One word per cycle sustained while the output is not stalled; each word passes
// the input register, then the counter update into the result register (output).
// Reset clears all counters, the tick latch and the rate; no clearing pass.
// A stalled output holds the result register and the input register; the input
// side keeps accepting while the input register can move on in the same cycle.
module packet_traffic_counters_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpc_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [tpc_pkg::LEN_W-1:0]     packet_length,
	input  logic [tpc_pkg::ADDR_W-1:0]    src_addr,
	input  logic [tpc_pkg::ADDR_W-1:0]    dst_addr,
	input  logic [tpc_pkg::PROTO_W-1:0]   ip_protocol,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tpc_pkg::CNT_W-1:0]     octets_all,
	output logic [tpc_pkg::CNT_W-1:0]     octets_in,
	output logic [tpc_pkg::CNT_W-1:0]     octets_out,
	output logic [tpc_pkg::CNT_W-1:0]     octets_tcp,
	output logic [tpc_pkg::CNT_W-1:0]     octets_udp,
	output logic [tpc_pkg::CNT_W-1:0]     octets_icmp,
	output logic [tpc_pkg::CNT_W-1:0]     packet_total,
	output logic [tpc_pkg::CNT_W-1:0]     rate_bytes,
	output logic                          rate_valid,
	output logic                          low_rate_alert
);

	tpc_pkg::cfg_t cfg;
	tpc_pkg::cls_t cls;
	tpc_pkg::upd_t upd;
	tpc_pkg::res_t nxt;
	tpc_pkg::res_t res_s2;

	logic                          valid_s1;
	logic                          op_s1;
	logic [tpc_pkg::LEN_W-1:0]     len_s1;
	logic [tpc_pkg::ADDR_W-1:0]    src_s1;
	logic [tpc_pkg::ADDR_W-1:0]    dst_s1;
	logic [tpc_pkg::PROTO_W-1:0]   proto_s1;
	logic                          valid_s2;
	logic                          adv;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	tpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= op;
			len_s1   <= packet_length;
			src_s1   <= src_addr;
			dst_s1   <= dst_addr;
			proto_s1 <= ip_protocol;
		end
	end

	tpc_classify u_classify (
		.cfg         (cfg),
		.src_addr    (src_s1),
		.dst_addr    (dst_s1),
		.ip_protocol (proto_s1),
		.cls         (cls)
	);

	assign upd.upd = adv;
	assign upd.op  = op_s1;
	assign upd.len = len_s1;
	assign upd.cls = cls;

	tpc_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.cfg    (cfg),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign octets_all     = res_s2.octets_all;
	assign octets_in      = res_s2.octets_in;
	assign octets_out     = res_s2.octets_out;
	assign octets_tcp     = res_s2.octets_tcp;
	assign octets_udp     = res_s2.octets_udp;
	assign octets_icmp    = res_s2.octets_icmp;
	assign packet_total   = res_s2.packet_total;
	assign rate_bytes     = res_s2.rate_bytes;
	assign rate_valid     = res_s2.rate_valid;
	assign low_rate_alert = res_s2.low_rate_alert;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without a blocked result");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result raised with no word in the input stage");

	a_alert_rate: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && low_rate_alert |-> rate_valid)
		else $error("alert raised without a computed rate");
`endif

endmodule
